/* rtl/deque_with_positional_insert_top_macros.svh */
// assertion macros for the deque with positional insert
`ifndef DEQUE_WITH_POSITIONAL_INSERT_TOP_MACROS_SVH
`define DEQUE_WITH_POSITIONAL_INSERT_TOP_MACROS_SVH

// same-cycle implication
`define DQPI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DQPI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/dqpi_pkg.sv */
// types and constants shared by the deque with positional insert
`default_nettype none

package dqpi_pkg;

  localparam int CAPACITY = 16;
  localparam int ID_WIDTH = 16;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int POS_W = 5;
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef logic [ID_WIDTH-1:0] id_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CMP_W-1:0] cmp_t;

  typedef logic [15:0] item_field_t;
  typedef logic [POS_W-1:0] pos_field_t;
  typedef logic [4:0] fill_field_t;

  typedef enum logic [1:0] {
    CMD_PUSH_BACK  = 2'd0,
    CMD_PUSH_FRONT = 2'd1,
    CMD_INSERT     = 2'd2,
    CMD_POP_FRONT  = 2'd3
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef struct packed {
    cmd_code_t   command;
    item_field_t item_id;
    pos_field_t  position;
  } cmd_word_t;

  typedef struct packed {
    status_t     status;
    item_field_t popped_id;
    fill_field_t fill_count;
  } rsp_word_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } dp_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
  } dp_sts_t;

endpackage

`default_nettype wire

/* rtl/dqpi_dp.sv */
// datapath: command register, entry row with parallel shift, count and response register
`default_nettype none

module dqpi_dp (
  input  wire                 clk,
  input  wire                 rst,
  input  dqpi_pkg::dp_ctl_t   ctl,
  output dqpi_pkg::dp_sts_t   sts,
  input  dqpi_pkg::cmd_word_t cmd_word,
  output dqpi_pkg::rsp_word_t rsp_word
);

  dqpi_pkg::cmd_word_t cur;
  dqpi_pkg::id_t       entries [dqpi_pkg::CAPACITY];
  dqpi_pkg::id_t       entries_next [dqpi_pkg::CAPACITY];
  dqpi_pkg::cnt_t      count;
  dqpi_pkg::cnt_t      count_next;
  dqpi_pkg::rsp_word_t rsp;
  dqpi_pkg::rsp_word_t rsp_next;

  dqpi_pkg::status_t status;
  dqpi_pkg::id_t     popped;
  dqpi_pkg::idx_t    idx;
  dqpi_pkg::cmp_t    cnt_ext;
  dqpi_pkg::cmp_t    pos_ext;
  dqpi_pkg::id_t     cur_id;
  logic              shift_left;
  logic              do_ins;
  logic              full;

  assign cnt_ext = dqpi_pkg::cmp_t'(count);
  assign pos_ext = dqpi_pkg::cmp_t'(cur.position);
  assign cur_id  = dqpi_pkg::id_t'(cur.item_id);
  assign full    = (count >= dqpi_pkg::cnt_t'(dqpi_pkg::CAPACITY));

  always_comb begin
    status     = dqpi_pkg::ST_DONE;
    popped     = '0;
    idx        = '0;
    shift_left = 1'b0;
    do_ins     = 1'b0;
    count_next = count;
    case (cur.command)
      dqpi_pkg::CMD_POP_FRONT: begin
        if (count == '0) begin
          status = dqpi_pkg::ST_EMPTY;
        end else begin
          popped     = entries[0];
          shift_left = 1'b1;
          count_next = count - dqpi_pkg::cnt_t'(1);
        end
      end
      dqpi_pkg::CMD_PUSH_BACK: begin
        if (full) begin
          status = dqpi_pkg::ST_FULL;
        end else begin
          idx    = dqpi_pkg::idx_t'(count);
          do_ins = 1'b1;
        end
      end
      dqpi_pkg::CMD_PUSH_FRONT: begin
        if (full) begin
          status = dqpi_pkg::ST_FULL;
        end else begin
          idx    = '0;
          do_ins = 1'b1;
        end
      end
      dqpi_pkg::CMD_INSERT: begin
        if (full) begin
          status = dqpi_pkg::ST_FULL;
        end else if (pos_ext == '0 || pos_ext > cnt_ext + dqpi_pkg::cmp_t'(1)) begin
          status = dqpi_pkg::ST_BADPOS;
        end else begin
          idx    = dqpi_pkg::idx_t'(pos_ext - dqpi_pkg::cmp_t'(1));
          do_ins = 1'b1;
        end
      end
      default: begin
        status = dqpi_pkg::ST_DONE;
      end
    endcase
    if (do_ins) begin
      count_next = count + dqpi_pkg::cnt_t'(1);
    end
  end

  // each entry picks its neighbor, the new id, or holds
  always_comb begin
    for (int i = 0; i < dqpi_pkg::CAPACITY; i++) begin
      entries_next[i] = entries[i];
    end
    if (shift_left) begin
      for (int i = 0; i < dqpi_pkg::CAPACITY - 1; i++) begin
        entries_next[i] = entries[i + 1];
      end
    end
    if (do_ins) begin
      for (int i = 1; i < dqpi_pkg::CAPACITY; i++) begin
        if (i > int'(idx)) begin
          entries_next[i] = entries[i - 1];
        end
      end
      for (int i = 0; i < dqpi_pkg::CAPACITY; i++) begin
        if (dqpi_pkg::idx_t'(i) == idx) begin
          entries_next[i] = cur_id;
        end
      end
    end
  end

  always_comb begin
    rsp_next.status     = status;
    rsp_next.popped_id  = dqpi_pkg::item_field_t'(popped);
    rsp_next.fill_count = dqpi_pkg::fill_field_t'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.exec) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cur <= cmd_word;
    end
    if (ctl.exec) begin
      for (int i = 0; i < dqpi_pkg::CAPACITY; i++) begin
        entries[i] <= entries_next[i];
      end
      rsp <= rsp_next;
    end
  end

  assign sts.empty = (count == '0);
  assign sts.full  = full;
  assign rsp_word  = rsp;

endmodule

`default_nettype wire

/* rtl/dqpi_ctrl.sv */
// controller: command acceptance, execute sequencing and response valid
`default_nettype none

module dqpi_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               cmd_valid,
  output logic              cmd_stall,
  output logic              rsp_valid,
  input  wire               rsp_stall,
  input  dqpi_pkg::dp_sts_t sts,
  output dqpi_pkg::dp_ctl_t ctl
);

  typedef enum logic {
    IDLE,
    EXEC
  } state_t;

  state_t state;
  logic   rsp_free;
  logic   busy_full;

  assign rsp_free  = !rsp_valid || !rsp_stall;
  // no word is taken while reset is held
  assign cmd_stall = rst || (state == EXEC);
  assign ctl.load  = cmd_valid && !cmd_stall;
  assign ctl.exec  = (state == EXEC) && rsp_free;

  // full and empty together would mean a broken count
  assign busy_full = sts.full && sts.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      rsp_valid <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (cmd_valid) begin
            state <= EXEC;
          end
        end
        EXEC: begin
          if (rsp_free && !busy_full) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
      if (ctl.exec) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/deque_with_positional_insert_top.sv */
// an accepted word is registered, then executed in the EXEC state once the output is free
// a new word is not taken until the accept then execute controller is back in IDLE
// the entry row shifts in parallel in the execute cycle, so depth does not lengthen execution
// the next word is taken while a response still waits in the output register
// synchronous reset empties the queue, clears rsp_valid and stalls the input; entries kept
// top level of the deque with positional insert
`default_nettype none

`include "deque_with_positional_insert_top_macros.svh"

module deque_with_positional_insert_top (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cmd_valid,
  output logic                cmd_stall,
  input  dqpi_pkg::cmd_word_t cmd_word,
  output logic                rsp_valid,
  input  wire                 rsp_stall,
  output dqpi_pkg::rsp_word_t rsp_word
);

  dqpi_pkg::dp_ctl_t ctl;
  dqpi_pkg::dp_sts_t sts;

  dqpi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  dqpi_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .sts      (sts),
    .cmd_word (cmd_word),
    .rsp_word (rsp_word)
  );

  `DQPI_ASSERT_NOW(a_fill_bound, rsp_valid, rsp_word.fill_count <= dqpi_pkg::CAPACITY, "fill count above capacity")
  `DQPI_ASSERT_NEXT(a_busy_after_accept, cmd_valid && !cmd_stall, cmd_stall, "not busy after accept")
  `DQPI_ASSERT_NOW(a_full_count, rsp_valid && rsp_word.status == dqpi_pkg::ST_FULL, rsp_word.fill_count == dqpi_pkg::CAPACITY, "full status with room left")
  `DQPI_ASSERT_NOW(a_empty_pop, rsp_valid && rsp_word.status == dqpi_pkg::ST_EMPTY, rsp_word.fill_count == '0 && rsp_word.popped_id == '0, "empty status with entries or id")

endmodule

`default_nettype wire
